// ----- sv/dac_yuv_to_rgb888_assert.svh -----
// Assertion macros for the YUV to RGB888 converter.
// Used by the top level only; needs nothing else.
`ifndef DAC_YUV_TO_RGB888_ASSERT_SVH
`define DAC_YUV_TO_RGB888_ASSERT_SVH

// Plain implication, checked every clock outside reset.
`define DYR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay between cause and effect.
`define DYR_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- sv/dyr_pkg.sv -----
// Shared widths, fixed-point constants and types of the YUV to RGB888 converter.
// No dependencies.
`default_nettype none

package dyr_pkg;

  // Port and register widths
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned OFF_W      = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned V_BITS     = 10;
  localparam int unsigned OUT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Y_OFFSET = 3'd0,
    CFG_U_OFFSET = 3'd1,
    CFG_V_OFFSET = 3'd2,
    CFG_Y_GAIN   = 3'd3,
    CFG_U_GAIN   = 3'd4,
    CFG_V_GAIN   = 3'd5
  } cfg_reg_e;

  // Internal datapath widths (mV with 12 fraction bits)
  localparam int unsigned MV_W = 34;  // offset-corrected, scaled sample
  localparam int unsigned PU_W = 50;  // sample times Q2.14 reciprocal
  localparam int unsigned CH_W = 36;  // rebuilt blue/red before clamp
  localparam int unsigned T_W  = 52;  // green numerator
  localparam int unsigned TC_W = 35;  // green numerator, saturated
  localparam int unsigned GP_W = 50;  // saturated numerator times 1/0.587
  localparam int unsigned LV_W = 22;  // clamped 0..700 mV
  localparam int unsigned X_W  = 30;  // level times 255
  localparam int unsigned M_W  = 33;  // reciprocal product for /175

  localparam int unsigned Q_SHIFT     = 14;
  localparam int unsigned G_SHIFT     = 28;
  localparam int unsigned LVL_SHIFT   = 14;
  localparam int unsigned RECIP_SHIFT = 24;

  // Q2.14 coefficients
  localparam logic signed [15:0] INV_0562 = 16'sd29153;
  localparam logic signed [15:0] INV_0710 = 16'sd23076;
  localparam logic signed [15:0] W_R      = 16'sd4899;
  localparam logic signed [15:0] W_B      = 16'sd1868;
  localparam logic        [15:0] INV_0587 = 16'd27911;

  localparam logic [LV_W-1:0] FULL_SCALE = 22'd2867200;  // 700 mV
  localparam logic [7:0]      OUT_MAX    = 8'd255;
  // ceil(2^24 / 175); exact for dividends up to 16 bits
  localparam logic [16:0]     RECIP_175  = 17'd95870;

  // Pipeline depths
  localparam int unsigned SCALE_LAT  = 1;
  localparam int unsigned MATRIX_LAT = 6;
  localparam int unsigned LEVEL_LAT  = 3;

  typedef struct packed {
    logic [LV_W-1:0] blue;
    logic [LV_W-1:0] green;
    logic [LV_W-1:0] red;
  } rgb_mv_t;

endpackage

`default_nettype wire

// ----- sv/dyr_scale.sv -----
// One channel front end: offset subtract and gain multiply, one register stage.
// Depends on dyr_pkg.
`default_nettype none

module dyr_scale #(
  parameter int unsigned CodeBits = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic [dyr_pkg::CODE_W-1:0]              code_i,
  input  wire logic [dyr_pkg::OFF_W-1:0]               offset_i,
  input  wire logic [dyr_pkg::GAIN_W-1:0]              gain_i,
  output logic signed [dyr_pkg::MV_W-1:0]              mv_o
);

  logic signed [CodeBits:0]             diff;
  logic signed [dyr_pkg::MV_W-1:0]      mv_d, mv_q;

  // unused upper code bits drop out here
  assign diff = $signed({1'b0, code_i[CodeBits-1:0]}) - $signed((CodeBits+1)'(offset_i));
  assign mv_d = dyr_pkg::MV_W'(diff) * dyr_pkg::MV_W'($signed({1'b0, gain_i}));

  always_ff @(posedge clk_i) begin
    mv_q <= mv_d;
  end

  assign mv_o = mv_q;

endmodule

`default_nettype wire

// ----- sv/dyr_matrix.sv -----
// Color matrix: rebuilds blue, red and green in mV and clamps them to 0..700 mV.
// Six register stages, one multiply or add level each. Depends on dyr_pkg.
`default_nettype none

module dyr_matrix (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic signed [dyr_pkg::MV_W-1:0] y_mv_i,
  input  wire logic signed [dyr_pkg::MV_W-1:0] u_mv_i,
  input  wire logic signed [dyr_pkg::MV_W-1:0] v_mv_i,
  output logic                                 valid_o,
  output dyr_pkg::rgb_mv_t                     rgb_o
);

  function automatic logic [dyr_pkg::LV_W-1:0] clamp_mv(
    input logic signed [dyr_pkg::CH_W-1:0] c
  );
    logic [dyr_pkg::LV_W-1:0] res;
    if (c < 0) begin
      res = '0;
    end else if (c > $signed({1'b0, dyr_pkg::CH_W'(dyr_pkg::FULL_SCALE)})) begin
      res = dyr_pkg::FULL_SCALE;
    end else begin
      res = c[dyr_pkg::LV_W-1:0];
    end
    return res;
  endfunction

  logic [dyr_pkg::MATRIX_LAT-1:0] vld_d, vld_q;

  // stage 2: chroma times reciprocal
  logic signed [dyr_pkg::PU_W-1:0] pu_d, pu_q, pv_d, pv_q;
  logic signed [dyr_pkg::MV_W-1:0] y2_q;
  // stage 3: blue and red
  logic signed [dyr_pkg::CH_W-1:0] b_d, b_q, r_d, r_q;
  logic signed [dyr_pkg::MV_W-1:0] y3_q;
  // stage 4: green numerator terms
  logic signed [dyr_pkg::T_W-1:0]  ys_d, ys_q, wr_d, wr_q, wb_d, wb_q;
  logic signed [dyr_pkg::CH_W-1:0] b4_q, r4_q;
  // stage 5: numerator sum, saturated; blue and red clamped
  logic signed [dyr_pkg::T_W-1:0]  t_sum;
  logic [dyr_pkg::TC_W-1:0]        tc_d, tc_q;
  logic [dyr_pkg::LV_W-1:0]        b5_q, r5_q, b6_q, r6_q, b7_q, r7_q;
  // stage 6 and 7: green
  logic [dyr_pkg::GP_W-1:0]        gp_d, gp_q;
  logic [dyr_pkg::LV_W-1:0]        g_raw, g_d, g_q;

  assign vld_d = {vld_q[dyr_pkg::MATRIX_LAT-2:0], valid_i};

  assign pu_d = dyr_pkg::PU_W'(u_mv_i) * dyr_pkg::PU_W'(dyr_pkg::INV_0562);
  assign pv_d = dyr_pkg::PU_W'(v_mv_i) * dyr_pkg::PU_W'(dyr_pkg::INV_0710);

  // arithmetic shift floors toward minus infinity
  assign b_d = dyr_pkg::CH_W'(pu_q >>> dyr_pkg::Q_SHIFT) + dyr_pkg::CH_W'(y2_q);
  assign r_d = dyr_pkg::CH_W'(pv_q >>> dyr_pkg::Q_SHIFT) + dyr_pkg::CH_W'(y2_q);

  assign ys_d = dyr_pkg::T_W'(y3_q) <<< dyr_pkg::Q_SHIFT;
  assign wr_d = dyr_pkg::T_W'(r_q) * dyr_pkg::T_W'(dyr_pkg::W_R);
  assign wb_d = dyr_pkg::T_W'(b_q) * dyr_pkg::T_W'(dyr_pkg::W_B);

  // Negative numerator gives negative green, which clamps to zero. Anything
  // at or above 2^35 is far beyond 700 mV, so saturating it keeps the clamp.
  assign t_sum = ys_q - wr_q - wb_q;
  always_comb begin
    if (t_sum[dyr_pkg::T_W-1]) begin
      tc_d = '0;
    end else if (|t_sum[dyr_pkg::T_W-2:dyr_pkg::TC_W]) begin
      tc_d = '1;
    end else begin
      tc_d = t_sum[dyr_pkg::TC_W-1:0];
    end
  end

  assign gp_d  = dyr_pkg::GP_W'(tc_q) * dyr_pkg::GP_W'(dyr_pkg::INV_0587);
  assign g_raw = gp_q[dyr_pkg::GP_W-1:dyr_pkg::G_SHIFT];
  assign g_d   = (g_raw > dyr_pkg::FULL_SCALE) ? dyr_pkg::FULL_SCALE : g_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pu_q <= pu_d;
    pv_q <= pv_d;
    y2_q <= y_mv_i;
    b_q  <= b_d;
    r_q  <= r_d;
    y3_q <= y2_q;
    ys_q <= ys_d;
    wr_q <= wr_d;
    wb_q <= wb_d;
    b4_q <= b_q;
    r4_q <= r_q;
    tc_q <= tc_d;
    b5_q <= clamp_mv(b4_q);
    r5_q <= clamp_mv(r4_q);
    gp_q <= gp_d;
    b6_q <= b5_q;
    r6_q <= r5_q;
    g_q  <= g_d;
    b7_q <= b6_q;
    r7_q <= r6_q;
  end

  assign valid_o     = vld_q[dyr_pkg::MATRIX_LAT-1];
  assign rgb_o.blue  = b7_q;
  assign rgb_o.green = g_q;
  assign rgb_o.red   = r7_q;

endmodule

`default_nettype wire

// ----- sv/dyr_level.sv -----
// Output mapping: 0..700 mV to 0..255, truncating, for all three colors.
// c*255/2867200 done as ((c*255) >> 14) / 175 by reciprocal. Depends on dyr_pkg.
`default_nettype none

module dyr_level (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire dyr_pkg::rgb_mv_t           rgb_i,
  output logic                            valid_o,
  output logic [dyr_pkg::OUT_W-1:0]       blue_o,
  output logic [dyr_pkg::OUT_W-1:0]       green_o,
  output logic [dyr_pkg::OUT_W-1:0]       red_o
);

  localparam int unsigned Lanes = 3;

  logic [dyr_pkg::LEVEL_LAT-1:0] vld_d, vld_q;
  logic [dyr_pkg::LV_W-1:0]      c_in [Lanes];
  logic [dyr_pkg::X_W-1:0]       x_q  [Lanes];
  logic [dyr_pkg::M_W-1:0]       m_q  [Lanes];
  logic [dyr_pkg::OUT_W-1:0]     lvl_q[Lanes];

  assign c_in[0] = rgb_i.blue;
  assign c_in[1] = rgb_i.green;
  assign c_in[2] = rgb_i.red;

  assign vld_d = {vld_q[dyr_pkg::LEVEL_LAT-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      x_q[i]   <= dyr_pkg::X_W'(c_in[i]) * dyr_pkg::X_W'(dyr_pkg::OUT_MAX);
      m_q[i]   <= dyr_pkg::M_W'(x_q[i][dyr_pkg::X_W-1:dyr_pkg::LVL_SHIFT])
                  * dyr_pkg::M_W'(dyr_pkg::RECIP_175);
      lvl_q[i] <= m_q[i][dyr_pkg::RECIP_SHIFT+dyr_pkg::OUT_W-1:dyr_pkg::RECIP_SHIFT];
    end
  end

  assign valid_o = vld_q[dyr_pkg::LEVEL_LAT-1];
  assign blue_o  = lvl_q[0];
  assign green_o = lvl_q[1];
  assign red_o   = lvl_q[2];

endmodule

`default_nettype wire

// ----- sv/dac_yuv_to_rgb888.sv -----
// Channel   Direction  Signals
// pixel     in         start, busy, y_code_i, u_code_i, v_code_i
// color     out        done_o, blue_o, green_o, red_o
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// One pixel per clock; a pixel taken with start passes the 1 scale, 6 color matrix
// and 3 output mapping stages before it appears on done_o.
// Throughput is set by the multiplier stages, each fully pipelined; busy stays low.
// Reset clears the valid bits and loads the register defaults; the data path
// registers are not reset. There is no output backpressure.
// Depends on dyr_pkg, dyr_scale, dyr_matrix, dyr_level and the assertion header.
`default_nettype none

`include "dac_yuv_to_rgb888_assert.svh"

module dac_yuv_to_rgb888 #(
  parameter int unsigned CODE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [dyr_pkg::CODE_W-1:0]        y_code_i,
  input  wire logic [dyr_pkg::CODE_W-1:0]        u_code_i,
  input  wire logic [dyr_pkg::CODE_W-1:0]        v_code_i,
  output logic                                   done_o,
  output logic [dyr_pkg::OUT_W-1:0]              blue_o,
  output logic [dyr_pkg::OUT_W-1:0]              green_o,
  output logic [dyr_pkg::OUT_W-1:0]              red_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dyr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dyr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned Latency =
    dyr_pkg::SCALE_LAT + dyr_pkg::MATRIX_LAT + dyr_pkg::LEVEL_LAT;

  logic [dyr_pkg::OFF_W-1:0]  y_off_q, u_off_q, v_off_q;
  logic [dyr_pkg::GAIN_W-1:0] y_gain_q, u_gain_q, v_gain_q;
  logic                       s1_vld_q;
  logic signed [dyr_pkg::MV_W-1:0] y_mv, u_mv, v_mv;
  logic                       mx_vld;
  dyr_pkg::rgb_mv_t           mx_rgb;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_off_q  <= 10'd64;
      u_off_q  <= 10'd512;
      v_off_q  <= 10'd512;
      y_gain_q <= 16'd2802;
      u_gain_q <= 16'd2802;
      v_gain_q <= 16'd2802;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dyr_pkg::CFG_Y_OFFSET: y_off_q  <= cfg_data_i[dyr_pkg::OFF_W-1:0];
        dyr_pkg::CFG_U_OFFSET: u_off_q  <= cfg_data_i[dyr_pkg::OFF_W-1:0];
        dyr_pkg::CFG_V_OFFSET: v_off_q  <= cfg_data_i[dyr_pkg::OFF_W-1:0];
        dyr_pkg::CFG_Y_GAIN:   y_gain_q <= cfg_data_i;
        dyr_pkg::CFG_U_GAIN:   u_gain_q <= cfg_data_i;
        dyr_pkg::CFG_V_GAIN:   v_gain_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  dyr_scale #(.CodeBits(CODE_BITS)) u_scale_y (
    .clk_i   (clk_i),
    .code_i  (y_code_i),
    .offset_i(y_off_q),
    .gain_i  (y_gain_q),
    .mv_o    (y_mv)
  );

  dyr_scale #(.CodeBits(CODE_BITS)) u_scale_u (
    .clk_i   (clk_i),
    .code_i  (u_code_i),
    .offset_i(u_off_q),
    .gain_i  (u_gain_q),
    .mv_o    (u_mv)
  );

  // red difference uses only its low 10 code bits
  dyr_scale #(.CodeBits(dyr_pkg::V_BITS)) u_scale_v (
    .clk_i   (clk_i),
    .code_i  (v_code_i),
    .offset_i(v_off_q),
    .gain_i  (v_gain_q),
    .mv_o    (v_mv)
  );

  dyr_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_vld_q),
    .y_mv_i (y_mv),
    .u_mv_i (u_mv),
    .v_mv_i (v_mv),
    .valid_o(mx_vld),
    .rgb_o  (mx_rgb)
  );

  dyr_level u_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(mx_vld),
    .rgb_i  (mx_rgb),
    .valid_o(done_o),
    .blue_o (blue_o),
    .green_o(green_o),
    .red_o  (red_o)
  );

  // every accepted pixel comes out after the full pipeline depth
  `DYR_ASSERT_DLY(a_pixel_out, clk_i, rst_ni, start && !busy, Latency, done_o, "pixel lost")
  // no result without a pixel taken the same depth earlier
  `DYR_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, done_o, $past(start, Latency), "stray result")

endmodule

`default_nettype wire

// ----- tb/sv/dac_yuv_to_rgb888_tb.sv -----
// Self-checking testbench for dac_yuv_to_rgb888: pixels are sent with start/busy and each
// done_o color triple is compared with an in-bench fixed-point model or a typed-in color.
// Depends on dyr_pkg and the dac_yuv_to_rgb888 RTL only.
`default_nettype none

module dac_yuv_to_rgb888_tb;

  localparam int unsigned PIPE_LAT    = 10;
  localparam int unsigned DRAIN_LIMIT = 200;
  localparam int unsigned N_PHASES    = 8;

  // conversion constants, Q2.14
  localparam longint K_INV_0562 = 29153;
  localparam longint K_INV_0710 = 23076;
  localparam longint K_INV_0587 = 27911;
  localparam longint K_W_R      = 4899;
  localparam longint K_W_B      = 1868;
  localparam longint MV_700     = 2867200;  // 700 mV, 12 fraction bits
  localparam longint LEVEL_MAX  = 255;

  // indexes with no register behind them
  localparam logic [dyr_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [dyr_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb888_t;

  typedef struct packed {
    logic [15:0] y;
    logic [15:0] u;
    logic [15:0] v;
    logic        fixed;  // expected color typed in below
    rgb888_t     rgb;
  } pixel_row_t;

  localparam int unsigned N_DIRECTED = 21;

  // some neutral, full-scale and masked-V rows have their colors typed in
  pixel_row_t directed_px [N_DIRECTED] = '{
    '{16'd64,    16'd512,   16'd512,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'd64,    16'd512,   16'hFE00,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'hFFFF,  16'd512,   16'hFE00,  1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'd0,     16'd512,   16'd512,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{16'hFFFF,  16'd512,   16'd512,   1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'd0,     16'd0,     16'd0,     1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd64,    16'hFFFF,  16'd512,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd64,    16'd0,     16'd512,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd64,    16'd512,   16'd1023,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd64,    16'd512,   16'd0,     1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd940,   16'd512,   16'd512,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd63,    16'd511,   16'd511,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd65,    16'd513,   16'd513,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'hAAAA,  16'h5555,  16'h5555,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'h5555,  16'hAAAA,  16'hAAAA,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd500,   16'd300,   16'd700,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd300,   16'd700,   16'd300,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd1000,  16'd1023,  16'd1023,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'd1023,  16'd0,     16'd0,     1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{16'h8000,  16'h8000,  16'h8200,  1'b0, '{8'd0,   8'd0,   8'd0  }}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [dyr_pkg::CODE_W-1:0]       y_code_i = '0;
  logic [dyr_pkg::CODE_W-1:0]       u_code_i = '0;
  logic [dyr_pkg::CODE_W-1:0]       v_code_i = '0;
  logic                             done_o;
  logic [dyr_pkg::OUT_W-1:0]        blue_o;
  logic [dyr_pkg::OUT_W-1:0]        green_o;
  logic [dyr_pkg::OUT_W-1:0]        red_o;
  logic                             cfg_we_i = 1'b0;
  logic [dyr_pkg::CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [dyr_pkg::CFG_DATA_W-1:0]   cfg_data_i = '0;

  // register copies used by the color model
  logic [9:0]  y_off_r = 10'd64;
  logic [9:0]  u_off_r = 10'd512;
  logic [9:0]  v_off_r = 10'd512;
  logic [15:0] y_gain_r = 16'd2802;
  logic [15:0] u_gain_r = 16'd2802;
  logic [15:0] v_gain_r = 16'd2802;

  rgb888_t rgb_due_q [$];
  int      n_pixels = 0;
  int      n_checked = 0;
  int      n_errors = 0;
  int      n_settings = 0;

  always #5 clk_i = ~clk_i;

  dac_yuv_to_rgb888 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .y_code_i   (y_code_i),
    .u_code_i   (u_code_i),
    .v_code_i   (v_code_i),
    .done_o     (done_o),
    .blue_o     (blue_o),
    .green_o    (green_o),
    .red_o      (red_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic logic [7:0] mv_to_level(input longint c);
    longint cl;
    cl = c;
    if (cl < 0) cl = 0;
    if (cl > MV_700) cl = MV_700;
    return 8'((cl * LEVEL_MAX) / MV_700);
  endfunction

  // offset, gain, inverse color-difference weighting and BT.601 green recovery
  function automatic rgb888_t yuv_to_rgb888(input logic [15:0] y_c, input logic [15:0] u_c,
                                            input logic [15:0] v_c);
    longint  yc, uc, vc, yo, uo, vo, yg, ug, vg;
    longint  y_mv, u_mv, v_mv, b_mv, r_mv, g_mv, num;
    rgb888_t px;
    yc = y_c;
    uc = u_c;
    vc = v_c[9:0];
    yo = y_off_r;
    uo = u_off_r;
    vo = v_off_r;
    yg = y_gain_r;
    ug = u_gain_r;
    vg = v_gain_r;
    y_mv = yg * (yc - yo);
    u_mv = ug * (uc - uo);
    v_mv = vg * (vc - vo);
    b_mv = ((u_mv * K_INV_0562) >>> 14) + y_mv;
    r_mv = ((v_mv * K_INV_0710) >>> 14) + y_mv;
    num  = y_mv * 16384 - K_W_R * r_mv - K_W_B * b_mv;
    g_mv = (num * K_INV_0587) >>> 28;
    px.blue  = mv_to_level(b_mv);
    px.green = mv_to_level(g_mv);
    px.red   = mv_to_level(r_mv);
    return px;
  endfunction

  // one register write; caller lowers cfg_we_i after its last write
  task automatic cfg_write(input logic [dyr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    unique case (idx)
      dyr_pkg::CFG_Y_OFFSET: y_off_r = data[9:0];
      dyr_pkg::CFG_U_OFFSET: u_off_r = data[9:0];
      dyr_pkg::CFG_V_OFFSET: v_off_r = data[9:0];
      dyr_pkg::CFG_Y_GAIN:   y_gain_r = data;
      dyr_pkg::CFG_U_GAIN:   u_gain_r = data;
      dyr_pkg::CFG_V_GAIN:   v_gain_r = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [9:0] yo, input logic [9:0] uo, input logic [9:0] vo,
                               input logic [15:0] yg, input logic [15:0] ug,
                               input logic [15:0] vg);
    // offsets carry junk above bit 9, and the unused indexes get writes too
    cfg_write(dyr_pkg::CFG_Y_OFFSET, {6'($urandom), yo});
    cfg_write(CFG_SPARE6, 16'($urandom));
    cfg_write(dyr_pkg::CFG_U_OFFSET, {6'($urandom), uo});
    cfg_write(dyr_pkg::CFG_V_OFFSET, {6'($urandom), vo});
    cfg_write(dyr_pkg::CFG_Y_GAIN, yg);
    cfg_write(dyr_pkg::CFG_U_GAIN, ug);
    cfg_write(CFG_SPARE7, 16'($urandom));
    cfg_write(dyr_pkg::CFG_V_GAIN, vg);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_pixel(input logic [15:0] y, input logic [15:0] u, input logic [15:0] v,
                            input logic fixed, input rgb888_t given);
    start    <= 1'b1;
    y_code_i <= y;
    u_code_i <= u;
    v_code_i <= v;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    rgb_due_q.push_back(fixed ? given : yuv_to_rgb888(y, u, v));
    n_pixels++;
  endtask

  // sender holds off until every pending color has come back or the drain limit is reached
  task automatic drain_colors;
    int waited;
    waited = 0;
    while (rgb_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (rgb_due_q.size() != 0) begin
      flag_mismatch($sformatf("%0d colors never arrived", rgb_due_q.size()));
      rgb_due_q.delete();
    end
  endtask

  // code near the offset so colors land inside 0..700 mV, with some raw noise
  function automatic logic [15:0] pick_code(input logic [9:0] off, input logic [15:0] gain,
                                            input int lim);
    int span, val;
    unique case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2:    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        span = int'(MV_700 / (longint'(gain) + 1)) + 8;
        if (span > 4000) span = 4000;
        val = int'(off) + int'($urandom_range(0, 2 * span)) - span;
        if (val < 0) val = 0;
        if (val > lim) val = lim;
        return 16'(val);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    rgb888_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (rgb_due_q.size() == 0) begin
        flag_mismatch($sformatf("color %0d/%0d/%0d with no pixel pending",
                                blue_o, green_o, red_o));
      end else begin
        want = rgb_due_q.pop_front();
        if (blue_o !== want.blue)
          flag_mismatch($sformatf("color %0d blue %0d, want %0d", n_checked, blue_o,
                                  want.blue));
        if (green_o !== want.green)
          flag_mismatch($sformatf("color %0d green %0d, want %0d", n_checked, green_o,
                                  want.green));
        if (red_o !== want.red)
          flag_mismatch($sformatf("color %0d red %0d, want %0d", n_checked, red_o,
                                  want.red));
        n_checked++;
      end
    end
  end

  initial begin
    int          n_items;
    logic        idle_on;
    logic [9:0]  yo, uo, vo;
    logic [15:0] yg, ug, vg, yc, uc, vc;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels under the reset register values
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(directed_px[i].y, directed_px[i].u, directed_px[i].v,
                 directed_px[i].fixed, directed_px[i].rgb);
    end
    start <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_colors();
      case (ph)
        0: begin
          yo = 10'd0;    uo = 10'd0;    vo = 10'd0;
          yg = 16'hFFFF; ug = 16'hFFFF; vg = 16'hFFFF;
          n_items = 40;
        end
        1: begin
          yo = 10'd1023; uo = 10'd1023; vo = 10'd1023;
          yg = 16'd0;    ug = 16'd0;    vg = 16'd0;
          n_items = 30;
        end
        2: begin
          yo = 10'd64;   uo = 10'd512;  vo = 10'd512;
          yg = 16'd2802; ug = 16'd2802; vg = 16'd2802;
          n_items = 60;
        end
        default: begin
          yo = 10'($urandom_range(0, 1023));
          uo = 10'($urandom_range(0, 1023));
          vo = 10'($urandom_range(0, 1023));
          yg = $urandom_range(0, 1) ? 16'($urandom_range(1, 8191)) : 16'($urandom);
          ug = $urandom_range(0, 1) ? 16'($urandom_range(1, 8191)) : 16'($urandom);
          vg = $urandom_range(0, 1) ? 16'($urandom_range(1, 8191)) : 16'($urandom);
          n_items = 64;
        end
      endcase
      apply_setting(yo, uo, vo, yg, ug, vg);

      idle_on = 1'b0;
      for (int k = 0; k < n_items; k++) begin
        if (k % 16 == 0) idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 2) != 0);
        yc = pick_code(y_off_r, y_gain_r, 65535);
        uc = pick_code(u_off_r, u_gain_r, 65535);
        vc = pick_code(v_off_r, v_gain_r, 1023);
        vc[15:10] = 6'($urandom);
        send_pixel(yc, uc, vc, 1'b0, '0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
      start <= 1'b0;
    end

    drain_colors();
    repeat (PIPE_LAT + 5) @(posedge clk_i);
    $display("sent %0d pixels (%0d directed) across %0d register settings incl. extremes;",
             n_pixels, N_DIRECTED, n_settings + 1);
    $display("checked %0d colors, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && rgb_due_q.size() == 0) begin
      $display("dac_yuv_to_rgb888_tb: PASS");
    end else begin
      $display("dac_yuv_to_rgb888_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for a transfer");
    $display("dac_yuv_to_rgb888_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
